### rtl/svh_pkg.sv
`default_nettype none
package svh_pkg;

   // item field widths fixed by the interface
   localparam int ACT_W = 2;
   localparam int QC_W  = 4;
   localparam int TQ_W  = 4;
   localparam int IDX_W = 10;

   // action codes
   localparam logic [ACT_W-1:0] ACT_GROUND  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_HAD_ONE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_HAD_ALL = 2'd2;
   localparam logic [ACT_W-1:0] ACT_READ    = 2'd3;

   // 1/sqrt2 in Q0.30, rounded
   localparam int              K_W        = 30;
   localparam logic [K_W-1:0]  RSQRT2_Q30 = 30'd759250125;
   localparam int              RND_SHIFT  = 30;

   typedef struct packed {
      logic valid;
      logic sub;
   } svh_op_type;

   typedef struct packed {
      logic busy;
      logic sat;
   } svh_stat_type;

endpackage
`default_nettype wire

### rtl/svh_store.sv
`default_nettype none
module svh_store #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 36
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

### rtl/svh_bfly_unit.sv
`default_nettype none
module svh_bfly_unit #(
   parameter int FRAC_BITS = 16,
   parameter int ADDR_W    = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  svh_pkg::svh_op_type         op,
   input  logic [ADDR_W-1:0]           op_addr,
   input  logic signed [FRAC_BITS+1:0] a_re,
   input  logic signed [FRAC_BITS+1:0] a_im,
   input  logic signed [FRAC_BITS+1:0] b_re,
   input  logic signed [FRAC_BITS+1:0] b_im,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic signed [FRAC_BITS+1:0] wr_re,
   output logic signed [FRAC_BITS+1:0] wr_im,
   output svh_pkg::svh_stat_type       stat
);
   import svh_pkg::*;

   localparam int AMP_W  = FRAC_BITS + 2;
   localparam int SUM_W  = AMP_W + 1;
   localparam int PROD_W = SUM_W + K_W;
   localparam int RES_W  = PROD_W - RND_SHIFT;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (RND_SHIFT - 1);
   localparam logic [RES_W-1:0]  MIN_MAG    = RES_W'(1) << (AMP_W - 1);
   localparam logic [AMP_W-1:0]  AMP_MIN    = {1'b1, {(AMP_W-1){1'b0}}};
   localparam logic [AMP_W-1:0]  AMP_MAX    = {1'b0, {(AMP_W-1){1'b1}}};

   // stage A: exact sum or difference
   logic                    sa_vld_ff, sa_vld_in;
   logic [ADDR_W-1:0]       sa_addr_ff;
   logic signed [SUM_W-1:0] sa_re_ff, sa_re_in;
   logic signed [SUM_W-1:0] sa_im_ff, sa_im_in;

   // stage B: magnitude times 1/sqrt2
   logic                    sb_vld_ff;
   logic [ADDR_W-1:0]       sb_addr_ff;
   logic [PROD_W-1:0]       pb_re_ff, pb_re_in;
   logic [PROD_W-1:0]       pb_im_ff, pb_im_in;
   logic                    nb_re_ff, nb_im_ff;
   logic [SUM_W-1:0]        mag_re, mag_im;

   logic [AMP_W:0]          res_re, res_im;

   // round half away from zero at bit 30, then clip; top bit flags a clip
   function automatic logic [AMP_W:0] round_sat(input logic [PROD_W-1:0] prod,
                                                input logic neg);
      logic [PROD_W-1:0] rsum;
      logic [RES_W-1:0]  mag;
      logic [AMP_W-1:0]  val;
      logic              clip;
      rsum = prod + ROUND_HALF;
      mag  = rsum[PROD_W-1:RND_SHIFT];
      if (neg) begin
         clip = mag > MIN_MAG;
         val  = clip ? AMP_MIN : AMP_W'(RES_W'(0) - mag);
      end else begin
         clip = mag >= MIN_MAG;
         val  = clip ? AMP_MAX : AMP_W'(mag);
      end
      return {clip, val};
   endfunction

   always_comb begin
      sa_vld_in = op.valid;
      if (op.sub) begin
         sa_re_in = SUM_W'(a_re) - SUM_W'(b_re);
         sa_im_in = SUM_W'(a_im) - SUM_W'(b_im);
      end else begin
         sa_re_in = SUM_W'(a_re) + SUM_W'(b_re);
         sa_im_in = SUM_W'(a_im) + SUM_W'(b_im);
      end
   end

   always_comb begin
      mag_re   = sa_re_ff[SUM_W-1] ? $unsigned(-sa_re_ff) : $unsigned(sa_re_ff);
      mag_im   = sa_im_ff[SUM_W-1] ? $unsigned(-sa_im_ff) : $unsigned(sa_im_ff);
      pb_re_in = mag_re * RSQRT2_Q30;
      pb_im_in = mag_im * RSQRT2_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
         sb_vld_ff <= 1'b0;
      end else begin
         sa_vld_ff <= sa_vld_in;
         sb_vld_ff <= sa_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sa_addr_ff <= op_addr;
      sa_re_ff   <= sa_re_in;
      sa_im_ff   <= sa_im_in;
      sb_addr_ff <= sa_addr_ff;
      pb_re_ff   <= pb_re_in;
      pb_im_ff   <= pb_im_in;
      nb_re_ff   <= sa_re_ff[SUM_W-1];
      nb_im_ff   <= sa_im_ff[SUM_W-1];
   end

   assign res_re    = round_sat(pb_re_ff, nb_re_ff);
   assign res_im    = round_sat(pb_im_ff, nb_im_ff);

   assign wr_en     = sb_vld_ff;
   assign wr_addr   = sb_addr_ff;
   assign wr_re     = $signed(res_re[AMP_W-1:0]);
   assign wr_im     = $signed(res_im[AMP_W-1:0]);
   assign stat.busy = sa_vld_ff | sb_vld_ff;
   assign stat.sat  = sb_vld_ff & (res_re[AMP_W] | res_im[AMP_W]);

endmodule
`default_nettype wire

### rtl/state_vector_hadamard_top.sv
`default_nettype none
// Fixed-point state-vector engine for up to QUBIT_LIMIT qubits. Amplitudes are
// complex, each part signed with FRAC_BITS fraction bits (Q1.16 by default),
// held in one 2^QUBIT_LIMIT-entry memory. csr_wr_data sets the qubit count n
// (values above QUBIT_LIMIT act as QUBIT_LIMIT); the count may only be changed
// while the block is idle, and the memory is not cleared by it. Every item
// returns exactly one result item. Actions: ground state (clears the whole
// memory, entry 0 = 1.0), Hadamard on one qubit, Hadamard on qubits 0..n-1,
// and read one amplitude. Bad qubit or index raises error and changes nothing;
// saturated reports any clipped butterfly output. The single butterfly unit
// and the one memory write port set the pace: a Hadamard sweep writes two
// entries per pair, issuing pair reads and then draining the unit; Hadamard-all
// takes n such sweeps; a Hadamard item ends with the handoff to the output
// register and the return to idle. After reset the block runs a clearing pass
// over the whole memory with req_stall high. req_stall is high for the whole
// time an item is in work; a finished result waits in the output register and
// does not block the next item from being accepted.
module state_vector_hadamard_top #(
   parameter int QUBIT_LIMIT = 10,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [svh_pkg::QC_W-1:0]      csr_wr_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [svh_pkg::ACT_W-1:0]     req_action,
   input  logic [svh_pkg::TQ_W-1:0]      req_target_qubit,
   input  logic [svh_pkg::IDX_W-1:0]     req_read_index,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [FRAC_BITS+1:0]   rsp_amp_real,
   output logic signed [FRAC_BITS+1:0]   rsp_amp_imag,
   output logic                          rsp_error,
   output logic                          rsp_saturated
);
   import svh_pkg::*;

   localparam int AMP_W = FRAC_BITS + 2;
   localparam int AW    = QUBIT_LIMIT;         // memory address width
   localparam int PW    = AW + 1;              // index wide enough to hold 2^n
   localparam int QW    = $clog2(QUBIT_LIMIT + 1);
   localparam int DW    = 2 * AMP_W;
   localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1) << FRAC_BITS;

   // sequencer states
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;  // memory clearing pass
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
   localparam logic [ST_W-1:0] ST_SWEEP = 3'd2;  // issue pair reads
   localparam logic [ST_W-1:0] ST_DRAIN = 3'd3;  // let the unit finish writing
   localparam logic [ST_W-1:0] ST_DONE  = 3'd4;  // hand result to output reg

   // control
   logic [ST_W-1:0]  state_ff, state_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic             clr_item_ff, clr_item_in;
   logic [QC_W-1:0]  qc_ff;
   logic             phase_ff, phase_in;
   logic             rv_ff, dv_ff;

   // sweep bookkeeping
   logic [QW-1:0]    q_ff, q_in;
   logic [QW-1:0]    last_q_ff, last_q_in;
   logic [PW-1:0]    i_ff, i_in;
   logic [AW-1:0]    ia_ff, ia_in;
   logic [AW-1:0]    ja_ff, ja_in;
   logic             sat_acc_ff, sat_acc_in;
   logic             p_err_ff, p_err_in;
   logic             p_read_ff, p_read_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [AMP_W-1:0] rsp_re_ff, rsp_im_ff;
   logic             rsp_err_ff, rsp_sat_ff;

   logic [QW-1:0]    n_qubits;
   logic [PW-1:0]    vec_size;
   logic [PW-1:0]    bit_mask, i_hi, i_next;
   logic             req_take, tgt_bad, idx_ok;
   logic             issue, drained, rsp_free, rsp_load, in_clear;

   // memory and unit wiring
   logic             mem_wr_en, mem_rd_en;
   logic [AW-1:0]    mem_wr_addr, mem_rd_addr_a, mem_rd_addr_b;
   logic [DW-1:0]    mem_wr_data, rd_a, rd_b;
   svh_op_type       u_op;
   svh_stat_type     u_stat;
   logic [AW-1:0]    u_op_addr, u_wr_addr;
   logic             u_wr_en;
   logic signed [AMP_W-1:0] u_wr_re, u_wr_im;
   logic signed [AMP_W-1:0] a_re, a_im, b_re, b_im;

   // active qubit count, capped
   assign n_qubits = (32'(qc_ff) > QUBIT_LIMIT) ? QW'(QUBIT_LIMIT) : QW'(qc_ff);
   assign vec_size = PW'(1) << n_qubits;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign tgt_bad   = 32'(req_target_qubit) >= 32'(n_qubits);
   assign idx_ok    = 32'(req_read_index) < 32'(vec_size);

   // pair walk: i has target bit clear, partner is i with it set.
   // next i: set the bit, add one so the carry skips it, clear it again.
   assign bit_mask  = PW'(1) << q_ff;
   assign i_hi      = i_ff | bit_mask;
   assign i_next    = (i_hi + PW'(1)) & ~bit_mask;

   assign issue     = (state_ff == ST_SWEEP) && !phase_ff;
   assign drained   = !rv_ff && !dv_ff && !u_stat.busy;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_DONE) && rsp_free;
   assign in_clear  = (state_ff == ST_CLEAR);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      clr_item_in = clr_item_ff;
      phase_in    = phase_ff;
      q_in        = q_ff;
      last_q_in   = last_q_ff;
      i_in        = i_ff;
      ia_in       = ia_ff;
      ja_in       = ja_ff;
      sat_acc_in  = sat_acc_ff;
      p_err_in    = p_err_ff;
      p_read_in   = p_read_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (&clr_addr_ff) begin
               state_in = clr_item_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               sat_acc_in = 1'b0;
               p_err_in   = 1'b0;
               p_read_in  = 1'b0;
               i_in       = '0;
               phase_in   = 1'b0;
               case (req_action)
                  ACT_GROUND: begin
                     clr_item_in = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  ACT_HAD_ONE: begin
                     if (tgt_bad) begin
                        p_err_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        q_in      = QW'(req_target_qubit);
                        last_q_in = QW'(req_target_qubit);
                        state_in  = ST_SWEEP;
                     end
                  end
                  ACT_HAD_ALL: begin
                     if (n_qubits == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        q_in      = '0;
                        last_q_in = n_qubits - QW'(1);
                        state_in  = ST_SWEEP;
                     end
                  end
                  default: begin
                     // read: data lands in the port A register next cycle
                     p_read_in = idx_ok;
                     p_err_in  = ~idx_ok;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (!phase_ff) begin
               ia_in    = i_ff[AW-1:0];
               ja_in    = i_hi[AW-1:0];
               i_in     = i_next;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (i_ff >= vec_size) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // next sweep reads what this one writes: wait for the last write
            if (drained) begin
               if (q_ff == last_q_ff) begin
                  state_in = ST_DONE;
               end else begin
                  q_in     = q_ff + QW'(1);
                  i_in     = '0;
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               clr_item_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (u_stat.sat) begin
         sat_acc_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_item_ff  <= 1'b0;
         qc_ff        <= QC_W'(1);
         phase_ff     <= 1'b0;
         rv_ff        <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_item_ff  <= clr_item_in;
         phase_ff     <= phase_in;
         rv_ff        <= issue;
         dv_ff        <= rv_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            qc_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      last_q_ff  <= last_q_in;
      i_ff       <= i_in;
      ia_ff      <= ia_in;
      ja_ff      <= ja_in;
      sat_acc_ff <= sat_acc_in;
      p_err_ff   <= p_err_in;
      p_read_ff  <= p_read_in;
   end

   // output register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_re_ff  <= p_read_ff ? rd_a[DW-1:AMP_W] : '0;
         rsp_im_ff  <= p_read_ff ? rd_a[AMP_W-1:0] : '0;
         rsp_err_ff <= p_err_ff;
         rsp_sat_ff <= sat_acc_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_amp_real  = $signed(rsp_re_ff);
   assign rsp_amp_imag  = $signed(rsp_im_ff);
   assign rsp_error     = rsp_err_ff;
   assign rsp_saturated = rsp_sat_ff;

   // memory: pair reads during a sweep, single read for the read action
   assign mem_rd_en     = issue | (req_take && (req_action == ACT_READ));
   assign mem_rd_addr_a = issue ? i_ff[AW-1:0] : AW'(req_read_index);
   assign mem_rd_addr_b = i_hi[AW-1:0];

   // clearing pass owns the write port; otherwise the unit writes back
   assign mem_wr_en   = in_clear | u_wr_en;
   assign mem_wr_addr = in_clear ? clr_addr_ff : u_wr_addr;
   assign mem_wr_data = in_clear
                        ? ((clr_addr_ff == '0) ? {AMP_ONE, {AMP_W{1'b0}}} : {DW{1'b0}})
                        : {u_wr_re, u_wr_im};

   svh_store #(
      .ADDR_W (AW),
      .DATA_W (DW)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // pair data holds for both ops: sum first, then difference
   assign a_re      = $signed(rd_a[DW-1:AMP_W]);
   assign a_im      = $signed(rd_a[AMP_W-1:0]);
   assign b_re      = $signed(rd_b[DW-1:AMP_W]);
   assign b_im      = $signed(rd_b[AMP_W-1:0]);
   assign u_op.valid = rv_ff | dv_ff;
   assign u_op.sub   = dv_ff;
   assign u_op_addr  = dv_ff ? ja_ff : ia_ff;

   svh_bfly_unit #(
      .FRAC_BITS (FRAC_BITS),
      .ADDR_W    (AW)
   ) u_bfly (
      .clock   (clock),
      .reset   (reset),
      .op      (u_op),
      .op_addr (u_op_addr),
      .a_re    (a_re),
      .a_im    (a_im),
      .b_re    (b_re),
      .b_im    (b_im),
      .wr_en   (u_wr_en),
      .wr_addr (u_wr_addr),
      .wr_re   (u_wr_re),
      .wr_im   (u_wr_im),
      .stat    (u_stat)
   );

   // sum and difference slots of one pair never overlap
   a_slot_excl: assert property (@(posedge clock) disable iff (reset)
      !(rv_ff && dv_ff))
      else $error("sum and difference ops issued together");

   // nothing is written back while the block reports idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !u_wr_en && !u_stat.busy)
      else $error("butterfly unit active while idle");

   // a finished item always reaches the output register
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid)
      else $error("result not presented after completion");

   // an erroneous action never runs a butterfly
   a_err_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_error && rsp_saturated))
      else $error("error and saturation on the same item");

endmodule
`default_nettype wire
